@@ sv/dess_pkg.sv @@
// Shared types, constants and helpers for the delayed event sum scheduler.
package dess_pkg;

  // Field widths and value range
  localparam int VAL_W          = 24;
  localparam int DELAY_W        = 17;
  localparam int TIME_W         = 32;
  localparam int FIRED_W        = 11;
  localparam int VAL_MAX        = 8388607;
  localparam int VAL_MIN        = -8388608;
  localparam int HEAP_DEPTH_DEF = 1024;

  // One heap slot: due time and amplitude
  typedef struct packed {
    logic        [TIME_W-1:0] due;
    logic signed [VAL_W-1:0]  amp;
  } entry_t;

  // Datapath commands issued by the controller
  typedef enum logic [3:0] {
    DP_NOP,
    DP_ACCEPT,
    DP_INSERT,
    DP_UP_READ,
    DP_UP_MOVE,
    DP_PLACE,
    DP_ROOT_READ,
    DP_POP_TAKE,
    DP_LAST_LOAD,
    DP_DN_READ_L,
    DP_DN_LEFT,
    DP_DN_MOVE,
    DP_FINISH
  } dp_op_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_ROOT_RD,
    ST_ROOT_CMP,
    ST_LAST_LD,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_CMP,
    ST_DONE
  } ctl_state_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic ins_ok;     // event nonzero and heap has room
    logic at_root;    // sift index is zero
    logic up_swap;    // held entry is earlier than the parent just read
    logic fill_zero;  // heap is empty
    logic root_due;   // root entry is due at or before now
    logic l_valid;    // left child of sift index exists
    logic dn_move;    // a child is earlier than the held entry
    logic out_free;   // output register can take a new item
  } dp_status_t;

  // Wrap-aware time order: a is before b
  function automatic logic earlier(input logic [TIME_W-1:0] a,
                                   input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return d[TIME_W-1];
  endfunction

endpackage

@@ sv/dess_ctrl.sv @@
// Sequencer for heap insert, due-check, pop and sift steps.
module dess_ctrl
  import dess_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_op_t     op
);

  ctl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_START;
      end
      ST_START: begin
        state_next = status.ins_ok ? ST_UP_CHK : ST_ROOT_RD;
      end
      ST_UP_CHK: begin
        state_next = status.at_root ? ST_ROOT_RD : ST_UP_CMP;
      end
      ST_UP_CMP: begin
        state_next = status.up_swap ? ST_UP_CHK : ST_ROOT_RD;
      end
      ST_ROOT_RD: begin
        state_next = status.fill_zero ? ST_DONE : ST_ROOT_CMP;
      end
      ST_ROOT_CMP: begin
        state_next = status.root_due ? ST_LAST_LD : ST_DONE;
      end
      ST_LAST_LD: begin
        state_next = status.fill_zero ? ST_ROOT_RD : ST_DN_RDL;
      end
      ST_DN_RDL: begin
        state_next = status.l_valid ? ST_DN_RDR : ST_ROOT_RD;
      end
      ST_DN_RDR: begin
        state_next = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        state_next = status.dn_move ? ST_DN_RDL : ST_ROOT_RD;
      end
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    op       = DP_NOP;
    in_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) op = DP_ACCEPT;
      end
      ST_START: begin
        if (status.ins_ok) op = DP_INSERT;
      end
      ST_UP_CHK: begin
        op = status.at_root ? DP_PLACE : DP_UP_READ;
      end
      ST_UP_CMP: begin
        op = status.up_swap ? DP_UP_MOVE : DP_PLACE;
      end
      ST_ROOT_RD: begin
        if (!status.fill_zero) op = DP_ROOT_READ;
      end
      ST_ROOT_CMP: begin
        if (status.root_due) op = DP_POP_TAKE;
      end
      ST_LAST_LD: begin
        if (!status.fill_zero) op = DP_LAST_LOAD;
      end
      ST_DN_RDL: begin
        op = status.l_valid ? DP_DN_READ_L : DP_PLACE;
      end
      ST_DN_RDR: begin
        op = DP_DN_LEFT;
      end
      ST_DN_CMP: begin
        op = status.dn_move ? DP_DN_MOVE : DP_PLACE;
      end
      ST_DONE: begin
        if (status.out_free) op = DP_FINISH;
      end
      default: op = DP_NOP;
    endcase
  end

endmodule

@@ sv/dess_datapath.sv @@
// Heap memory, sift registers, accumulator, tick counter and output register.
module dess_datapath
  import dess_pkg::*;
#(
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dp_op_t                    op,
  output dp_status_t                status,
  input  logic signed [VAL_W-1:0]   event_value,
  input  logic signed [DELAY_W-1:0] delay_samples,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic signed [VAL_W-1:0]   sum_out,
  output logic                      event_dropped,
  output logic [FIRED_W-1:0]        fired_count
);

  localparam int IW = $clog2(HEAP_DEPTH);      // slot index
  localparam int FW = $clog2(HEAP_DEPTH + 1);  // fill count
  localparam int CW = IW + 2;                  // child index before range check
  localparam int AW = VAL_W + IW + 1;          // exact sum of a full heap
  localparam logic [FW-1:0]        FILL_FULL = FW'(HEAP_DEPTH);
  localparam logic signed [AW-1:0] SUM_MAX   = AW'(VAL_MAX);
  localparam logic signed [AW-1:0] SUM_MIN   = AW'(VAL_MIN);

  // Heap storage
  entry_t mem [HEAP_DEPTH];
  entry_t rd_q;
  logic   rd_en, wr_en;
  logic [IW-1:0] rd_idx, wr_idx;
  entry_t wr_data;

  // Control registers
  logic [FW-1:0]     fill;
  logic [TIME_W-1:0] now;

  // Work registers
  entry_t                  cur;
  logic [IW-1:0]           idx;
  entry_t                  best;
  logic [IW-1:0]           best_idx;
  logic                    best_move;
  logic signed [VAL_W-1:0] val_q;
  logic                    drop_q;
  logic signed [AW-1:0]    acc;
  logic [FIRED_W-1:0]      fired;

  // Index arithmetic
  logic [CW-1:0]     left_c, right_c;
  logic [IW-1:0]     parent_idx, left_idx, right_idx, last_idx;
  logic              r_valid, choose_right;
  entry_t            chosen;
  logic [IW-1:0]     chosen_idx;
  logic [TIME_W-1:0] delay_ext;
  logic signed [VAL_W-1:0] sat_sum;

  assign left_c     = {1'b0, idx, 1'b1};
  assign right_c    = left_c + CW'(1);
  assign left_idx   = left_c[IW-1:0];
  assign right_idx  = right_c[IW-1:0];
  assign parent_idx = IW'((idx - IW'(1)) >> 1);
  assign last_idx   = IW'(fill - FW'(1));
  assign r_valid    = right_c < CW'(fill);

  // Pick among held entry, left child and right child
  assign choose_right = r_valid && earlier(rd_q.due, best.due);
  assign chosen       = choose_right ? rd_q : best;
  assign chosen_idx   = choose_right ? right_idx : best_idx;

  // Negative delays clamp to zero
  assign delay_ext = delay_samples[DELAY_W-1] ? '0 :
                     TIME_W'(delay_samples[DELAY_W-2:0]);

  // Saturate the exact sum to the output range
  always_comb begin
    if (acc > SUM_MAX) begin
      sat_sum = VAL_W'(SUM_MAX);
    end else if (acc < SUM_MIN) begin
      sat_sum = VAL_W'(SUM_MIN);
    end else begin
      sat_sum = acc[VAL_W-1:0];
    end
  end

  // Status to the controller
  always_comb begin
    status.ins_ok    = (val_q != '0) && (fill != FILL_FULL);
    status.at_root   = (idx == '0);
    status.up_swap   = earlier(cur.due, rd_q.due);
    status.fill_zero = (fill == '0);
    status.root_due  = !earlier(now, rd_q.due);
    status.l_valid   = left_c < CW'(fill);
    status.dn_move   = choose_right || best_move;
    status.out_free  = !out_valid || !out_stall;
  end

  // Memory port selection
  always_comb begin
    rd_en  = 1'b0;
    rd_idx = '0;
    unique case (op)
      DP_UP_READ:   begin rd_en = 1'b1; rd_idx = parent_idx; end
      DP_ROOT_READ: begin rd_en = 1'b1; rd_idx = '0;         end
      DP_POP_TAKE:  begin rd_en = 1'b1; rd_idx = last_idx;   end
      DP_DN_READ_L: begin rd_en = 1'b1; rd_idx = left_idx;   end
      DP_DN_LEFT:   begin rd_en = r_valid; rd_idx = right_idx; end
      default: ;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = idx;
    wr_data = cur;
    unique case (op)
      DP_UP_MOVE: begin wr_en = 1'b1; wr_data = rd_q;   end
      DP_PLACE:   begin wr_en = 1'b1; wr_data = cur;    end
      DP_DN_MOVE: begin wr_en = 1'b1; wr_data = chosen; end
      default: ;
    endcase
  end

  // Heap memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    if (rd_en) rd_q <= mem[rd_idx];
  end

  // Fill count and tick counter
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      now  <= '0;
    end else begin
      if (op == DP_INSERT) fill <= fill + FW'(1);
      if (op == DP_POP_TAKE) fill <= fill - FW'(1);
      if (op == DP_FINISH) now <= now + TIME_W'(1);
    end
  end

  // Sift and accumulate registers
  always_ff @(posedge clk) begin
    case (op)
      DP_ACCEPT: begin
        val_q   <= event_value;
        drop_q  <= (event_value != '0) && (fill == FILL_FULL);
        cur.due <= now + delay_ext;
        cur.amp <= event_value;
        acc     <= '0;
        fired   <= '0;
      end
      DP_INSERT: idx <= IW'(fill);
      DP_UP_MOVE: idx <= parent_idx;
      DP_POP_TAKE: begin
        acc   <= acc + AW'(rd_q.amp);
        fired <= fired + FIRED_W'(1);
      end
      DP_LAST_LOAD: begin
        cur <= rd_q;
        idx <= '0;
      end
      DP_DN_LEFT: begin
        if (earlier(rd_q.due, cur.due)) begin
          best      <= rd_q;
          best_idx  <= left_idx;
          best_move <= 1'b1;
        end else begin
          best      <= cur;
          best_idx  <= idx;
          best_move <= 1'b0;
        end
      end
      DP_DN_MOVE: idx <= chosen_idx;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == DP_FINISH) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == DP_FINISH) begin
      sum_out       <= sat_sum;
      event_dropped <= drop_q;
      fired_count   <= fired;
    end
  end

endmodule

@@ sv/delayed_event_sum_scheduler.sv @@
// From accept to out_valid: an insert, if any, sifts up to the root or stops below; the root
//   is then checked once per pop plus once more, once only for an empty heap; each pop that
//   leaves entries moves the last entry to the root and sifts it down until it has no earlier child.
// One item at a time: the next is taken only once the last result is loaded into the output
//   register, after any wait for a stalled result register.
// Reset: clears fill count, tick counter, sequencer and output valid; heap memory is kept.
module delayed_event_sum_scheduler
  import dess_pkg::*;
#(
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VAL_W-1:0]   event_value,
  input  logic signed [DELAY_W-1:0] delay_samples,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VAL_W-1:0]   sum_out,
  output logic                      event_dropped,
  output logic [FIRED_W-1:0]        fired_count
);

  dp_op_t     op;
  dp_status_t status;

  // Sequencer
  dess_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .op       (op)
  );

  // Heap and arithmetic
  dess_datapath #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .status        (status),
    .event_value   (event_value),
    .delay_samples (delay_samples),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .sum_out       (sum_out),
    .event_dropped (event_dropped),
    .fired_count   (fired_count)
  );

endmodule

@@ sv/dess_checker.sv @@
// Port-level checks for the delayed event sum scheduler, bound to the top level.
module dess_checker
  import dess_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [VAL_W-1:0] sum_out,
  input logic                    event_dropped,
  input logic [FIRED_W-1:0]      fired_count
);

  // One item at a time: an accepted item holds off the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accept");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sum_out) &&
      $stable(event_dropped) && $stable(fired_count))
    else $error("stalled result changed");

  // Nothing fired means an empty sum
  a_zero_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid && fired_count == '0 |-> sum_out == '0)
    else $error("nonzero sum with no event fired");

  // Reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind delayed_event_sum_scheduler dess_checker u_dess_checker (.*);

@@ dv/event_sum_checker.sv @@
`timescale 1ns / 1ps
// Checker for the delayed event sum scheduler: watches channels, predicts ticks, scores results.
module event_sum_checker
  import dess_pkg::*;
#(
  parameter int DEPTH = HEAP_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic signed [VAL_W-1:0]   event_value,
  input  logic signed [DELAY_W-1:0] delay_samples,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [VAL_W-1:0]   sum_out,
  input  logic                      event_dropped,
  input  logic [FIRED_W-1:0]        fired_count,
  output int                        fails,
  output int                        pending
);

  localparam int REPORT_CAP = 100;

  // Expected outcome of one tick
  typedef struct packed {
    logic signed [VAL_W-1:0] sum;
    logic                    dropped;
    logic [FIRED_W-1:0]      count;
  } tick_result_t;

  // Predicted scheduler state
  logic [TIME_W-1:0]       slot_due [DEPTH];
  logic signed [VAL_W-1:0] slot_amp [DEPTH];
  int                      occupancy = 0;
  logic [TIME_W-1:0]       cur_tick = '0;

  tick_result_t tick_results_q [$];
  int           fail_tally = 0;

  // Wrap-aware order: a comes strictly before b
  function automatic bit due_first(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] diff;
    diff = a - b;
    return diff[TIME_W-1];
  endfunction

  function automatic void exchange(input int a, input int b);
    logic [TIME_W-1:0]       t;
    logic signed [VAL_W-1:0] v;
    t = slot_due[a];
    v = slot_amp[a];
    slot_due[a] = slot_due[b];
    slot_amp[a] = slot_amp[b];
    slot_due[b] = t;
    slot_amp[b] = v;
  endfunction

  // Append at the bottom, sift up
  function automatic void heap_insert(input logic [TIME_W-1:0] due,
                                      input logic signed [VAL_W-1:0] amp);
    int i;
    int parent;
    i = occupancy;
    slot_due[i] = due;
    slot_amp[i] = amp;
    occupancy++;
    while (i > 0) begin
      parent = (i - 1) / 2;
      if (!due_first(slot_due[i], slot_due[parent])) break;
      exchange(i, parent);
      i = parent;
    end
  endfunction

  // Move the last entry to the root, sift down
  function automatic void heap_remove_root();
    int i;
    int lc;
    int rc;
    int pick;
    occupancy--;
    slot_due[0] = slot_due[occupancy];
    slot_amp[0] = slot_amp[occupancy];
    i = 0;
    while (1) begin
      lc = 2 * i + 1;
      rc = lc + 1;
      pick = i;
      if (lc < occupancy && due_first(slot_due[lc], slot_due[pick])) pick = lc;
      if (rc < occupancy && due_first(slot_due[rc], slot_due[pick])) pick = rc;
      if (pick == i) break;
      exchange(i, pick);
      i = pick;
    end
  endfunction

  // One sample tick: schedule the event, fire everything due, advance time
  function automatic tick_result_t advance_tick(input logic signed [VAL_W-1:0] value,
                                                input logic signed [DELAY_W-1:0] delay);
    logic [TIME_W-1:0] wait_ticks;
    longint            total;
    int                popped;
    tick_result_t      r;
    wait_ticks = '0;
    if (!delay[DELAY_W-1]) wait_ticks[DELAY_W-2:0] = delay[DELAY_W-2:0];
    r.dropped = 1'b0;
    if (value != 0) begin
      if (occupancy >= DEPTH) r.dropped = 1'b1;
      else heap_insert(cur_tick + wait_ticks, value);
    end
    total = 0;
    popped = 0;
    while (occupancy > 0 && !due_first(cur_tick, slot_due[0])) begin
      total += slot_amp[0];
      popped++;
      heap_remove_root();
    end
    if (total > VAL_MAX) total = VAL_MAX;
    if (total < VAL_MIN) total = VAL_MIN;
    r.sum = VAL_W'(total);
    r.count = FIRED_W'(popped);
    cur_tick = cur_tick + 1;
    return r;
  endfunction

  // Predict on accepted items, score accepted results
  always @(posedge clk) begin : score
    tick_result_t want;
    if (rst) begin
      occupancy = 0;
      cur_tick = '0;
      tick_results_q.delete();
      pending <= 0;
      fails <= fail_tally;
    end else begin
      if (in_valid && !in_stall)
        tick_results_q.push_back(advance_tick(event_value, delay_samples));
      if (out_valid && !out_stall) begin
        if (tick_results_q.size() == 0) begin
          fail_tally++;
          if (fail_tally <= REPORT_CAP)
            $error("sum_out: no tick outstanding, expected nothing, got %0d", sum_out);
        end else begin
          want = tick_results_q.pop_front();
          if (sum_out !== want.sum) begin
            fail_tally++;
            if (fail_tally <= REPORT_CAP)
              $error("sum_out: expected %0d, got %0d", $signed(want.sum), sum_out);
          end
          if (event_dropped !== want.dropped) begin
            fail_tally++;
            if (fail_tally <= REPORT_CAP)
              $error("event_dropped: expected %0d, got %0d", want.dropped, event_dropped);
          end
          if (fired_count !== want.count) begin
            fail_tally++;
            if (fail_tally <= REPORT_CAP)
              $error("fired_count: expected %0d, got %0d", want.count, fired_count);
          end
        end
      end
      pending <= tick_results_q.size();
      fails <= fail_tally;
    end
  end

endmodule

@@ dv/delayed_event_sum_scheduler_tb.sv @@
`timescale 1ns / 1ps
// Top of the delayed event sum scheduler testbench: clock, reset, item traffic and verdict.
module delayed_event_sum_scheduler_tb;
  import dess_pkg::*;

  localparam int WATCHDOG_LIMIT = 250000;
  localparam int SETTLE_CYCLES  = 300;
  localparam int HOLD_CYCLES    = 600;
  localparam int FILL_TARGET    = 1100;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [VAL_W-1:0]   event_value = '0;
  logic signed [DELAY_W-1:0] delay_samples = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VAL_W-1:0]   sum_out;
  logic                      event_dropped;
  logic [FIRED_W-1:0]        fired_count;

  int fails;
  int pending;
  int results_taken = 0;
  int idle_cycles = 0;
  int src_burst = 0;

  always #5 clk = ~clk;

  delayed_event_sum_scheduler i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .event_value   (event_value),
    .delay_samples (delay_samples),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sum_out       (sum_out),
    .event_dropped (event_dropped),
    .fired_count   (fired_count)
  );

  event_sum_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .event_value   (event_value),
    .delay_samples (delay_samples),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sum_out       (sum_out),
    .event_dropped (event_dropped),
    .fired_count   (fired_count),
    .fails         (fails),
    .pending       (pending)
  );

  // Result count drives the one long receiver hold-off
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) results_taken <= results_taken + 1;
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** delayed_event_sum_scheduler: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Random gap length: mostly short, some long, with gap-free bursts
  function automatic int pick_gap();
    int r;
    if (src_burst > 0) begin
      src_burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      src_burst = $urandom_range(20, 60);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) begin
      case ($urandom_range(0, 3))
        0: return VAL_W'(VAL_MAX);
        1: return VAL_W'(VAL_MIN);
        2: return VAL_W'(1);
        default: return VAL_W'(-1);
      endcase
    end
    return VAL_W'($urandom());
  endfunction

  // Mostly short delays so events overlap in the heap; a few negative or far out
  function automatic logic signed [DELAY_W-1:0] rand_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return {1'b1, 16'($urandom())};
    if (r < 14) return DELAY_W'($urandom_range(1000, 65535));
    if (r < 30) return '0;
    return DELAY_W'($urandom_range(1, 40));
  endfunction

  // Offer one item after an optional gap and hold it until accepted
  task automatic send_item(input logic signed [VAL_W-1:0] value,
                           input logic signed [DELAY_W-1:0] delay);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    event_value   <= value;
    delay_samples <= delay;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Receiver: random stalls, calm runs, and one long hold-off
  initial begin : sink
    int  hold;
    int  run;
    bit  pressure_done;
    pressure_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!pressure_done && results_taken >= 50) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        pressure_done = 1'b1;
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          hold = 0;
          run  = $urandom_range(30, 120);
        end else begin
          case ($urandom_range(0, 99)) inside
            [0:49]:  hold = 0;
            [50:84]: hold = $urandom_range(1, 3);
            [85:96]: hold = $urandom_range(4, 15);
            default: hold = $urandom_range(30, 150);
          endcase
          run = $urandom_range(1, 8);
        end
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat (run) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    int                        lag;
    logic signed [VAL_W-1:0]   v;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: no event, extremes, same-tick fire, clamped delays
    send_item('0, '0);
    send_item('0, DELAY_W'(-1));
    send_item(VAL_W'(VAL_MAX), '0);
    send_item(VAL_W'(VAL_MIN), '0);
    send_item(VAL_W'(1), DELAY_W'(-1));
    send_item(VAL_W'(-1), DELAY_W'(-65536));
    send_item(VAL_W'(123), DELAY_W'(65535));
    // Four maxima due on one tick saturate high
    send_item(VAL_W'(VAL_MAX), DELAY_W'(3));
    send_item(VAL_W'(VAL_MAX), DELAY_W'(2));
    send_item(VAL_W'(VAL_MAX), DELAY_W'(1));
    send_item(VAL_W'(VAL_MAX), '0);
    // Four minima due on one tick saturate low
    send_item(VAL_W'(VAL_MIN), DELAY_W'(3));
    send_item(VAL_W'(VAL_MIN), DELAY_W'(2));
    send_item(VAL_W'(VAL_MIN), DELAY_W'(1));
    send_item(VAL_W'(VAL_MIN), '0);
    // Opposite extremes sum to -1; two halves land exactly on the top value
    send_item(VAL_W'(VAL_MAX), DELAY_W'(1));
    send_item(VAL_W'(VAL_MIN), '0);
    send_item(VAL_W'(4194304), DELAY_W'(1));
    send_item(VAL_W'(4194303), '0);

    // Random mix
    repeat (300) send_item(rand_value(), rand_delay());

    // Fill the heap: events all due near one tick, so it overflows and then
    // drains hundreds of events at once
    for (int k = 0; k < FILL_TARGET + 10; k++) begin
      lag = FILL_TARGET - k;
      if ($urandom_range(0, 3) == 0) lag -= $urandom_range(0, 30);
      if (lag < 0) lag = 0;
      v = VAL_W'($urandom());
      if ($urandom_range(0, 63) == 0) v = '0;
      else if (v == 0) v = VAL_W'(1);
      send_item(v, DELAY_W'(lag));
    end

    // Random mix after the drain
    repeat (420) send_item(rand_value(), rand_delay());

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("** delayed_event_sum_scheduler: PASSED **");
    end else begin
      $display("** delayed_event_sum_scheduler: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/dess_pkg.sv
sv/dess_ctrl.sv
sv/dess_datapath.sv
sv/delayed_event_sum_scheduler.sv
sv/dess_checker.sv
dv/event_sum_checker.sv
dv/delayed_event_sum_scheduler_tb.sv
